// ===== rtl/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg
// Types, constants and helpers shared by the dense run detector modules.
// ----------------------------------------------------------------------------
package drd_pkg;

   localparam int RANK_BITS = 32;
   localparam int PRED_BITS = 16;

   localparam int RANK_CMP_BITS = (RANK_BITS < 32) ? RANK_BITS : 32;

   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;

   localparam logic REG_ROW_TOTAL       = 1'b0;
   localparam logic REG_DENSE_THRESHOLD = 1'b1;

   localparam logic [PRED_BITS-1:0] PRED_MAX = {PRED_BITS{1'b1}};
   localparam logic [47:0]          SUM_MAX  = {48{1'b1}};
   localparam logic [31:0]          LEN_MAX  = {32{1'b1}};

   typedef struct packed {
      logic [31:0] run_rank;
      logic [31:0] run_extent;
      logic        column_end;
      logic        new_frame;
   } req_type;

   typedef struct packed {
      logic [15:0] predictor_index;
      logic        dense_found;
      logic [31:0] dense_rank;
      logic [31:0] explicit_count;
      logic [47:0] storage_offset;
      logic [15:0] dense_index;
   } rsp_type;

   typedef struct packed {
      logic [31:0] row_total;
      logic [31:0] dense_threshold;
   } cfg_type;

   function automatic logic [PRED_BITS-1:0] bump_pred(input logic [PRED_BITS-1:0] v);
      return (v == PRED_MAX) ? PRED_MAX : v + PRED_BITS'(1);
   endfunction

endpackage

// ===== rtl/drd_csr.sv =====
// ----------------------------------------------------------------------------
// drd_csr
// APB-style register file holding the row total and the dense threshold.
// ----------------------------------------------------------------------------
module drd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [drd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [drd_pkg::DATA_BITS-1:0] pwdata,
   output logic [drd_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready,
   output drd_pkg::cfg_type              cfg
);

   drd_pkg::cfg_type cfg_ff;
   drd_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            drd_pkg::REG_ROW_TOTAL:       cfg_in.row_total       = pwdata;
            drd_pkg::REG_DENSE_THRESHOLD: cfg_in.dense_threshold = pwdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         drd_pkg::REG_ROW_TOTAL:       prdata = cfg_ff.row_total;
         drd_pkg::REG_DENSE_THRESHOLD: prdata = cfg_ff.dense_threshold;
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/drd_run_tracker.sv =====
// ----------------------------------------------------------------------------
// drd_run_tracker
// Merges equal-rank runs, tracks the longest run of a column and builds the
// column result together with the running offset accumulators.
// ----------------------------------------------------------------------------
module drd_run_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  drd_pkg::req_type req,
   input  drd_pkg::cfg_type cfg,
   output logic             push,
   output drd_pkg::rsp_type result
);

   localparam int RB = drd_pkg::RANK_CMP_BITS;
   localparam int PB = drd_pkg::PRED_BITS;

   logic [RB-1:0] prev_rank_ff,  prev_rank_in;
   logic          first_ff,      first_in;
   logic [31:0]   cur_len_ff,    cur_len_in;
   logic [31:0]   long_len_ff,   long_len_in;
   logic [RB-1:0] long_rank_ff,  long_rank_in;
   logic [PB-1:0] sparse_cnt_ff, sparse_cnt_in;
   logic [PB-1:0] dense_cnt_ff,  dense_cnt_in;
   logic [47:0]   dense_sum_ff,  dense_sum_in;
   logic [PB-1:0] col_cnt_ff,    col_cnt_in;

   logic [RB-1:0] rank;
   logic          new_run;
   logic [32:0]   merge_sum;
   logic [31:0]   cur_len;
   logic          longer;
   logic [31:0]   long_len;
   logic [RB-1:0] long_rank;
   logic [PB-1:0] sparse_cnt;
   logic [PB-1:0] dense_cnt;
   logic [47:0]   dense_sum;
   logic [PB-1:0] col_cnt;
   logic          dense;
   logic [31:0]   expl;
   logic [48:0]   sum_next;

   always_comb begin
      rank       = req.run_rank[RB-1:0];
      new_run    = first_ff || (rank != prev_rank_ff);
      merge_sum  = {1'b0, cur_len_ff} + {1'b0, req.run_extent};
      if (new_run) begin
         cur_len = req.run_extent;
      end else begin
         cur_len = merge_sum[32] ? drd_pkg::LEN_MAX : merge_sum[31:0];
      end
      longer     = cur_len > long_len_ff;
      long_len   = longer ? cur_len : long_len_ff;
      long_rank  = longer ? rank : long_rank_ff;

      sparse_cnt = req.new_frame ? '0 : sparse_cnt_ff;
      dense_cnt  = req.new_frame ? '0 : dense_cnt_ff;
      dense_sum  = req.new_frame ? '0 : dense_sum_ff;
      col_cnt    = req.new_frame ? '0 : col_cnt_ff;

      dense      = long_len > cfg.dense_threshold;
      expl       = (long_len > cfg.row_total) ? 32'd0 : cfg.row_total - long_len;
      sum_next   = {1'b0, dense_sum} + {17'd0, expl};

      prev_rank_in  = prev_rank_ff;
      first_in      = first_ff;
      cur_len_in    = cur_len_ff;
      long_len_in   = long_len_ff;
      long_rank_in  = long_rank_ff;
      sparse_cnt_in = sparse_cnt_ff;
      dense_cnt_in  = dense_cnt_ff;
      dense_sum_in  = dense_sum_ff;
      col_cnt_in    = col_cnt_ff;

      if (accept) begin
         sparse_cnt_in = sparse_cnt;
         dense_cnt_in  = dense_cnt;
         dense_sum_in  = dense_sum;
         col_cnt_in    = col_cnt;
         if (req.column_end) begin
            prev_rank_in = '0;
            first_in     = 1'b1;
            cur_len_in   = '0;
            long_len_in  = '0;
            long_rank_in = '0;
            col_cnt_in   = drd_pkg::bump_pred(col_cnt);
            if (dense) begin
               dense_sum_in = sum_next[48] ? drd_pkg::SUM_MAX : sum_next[47:0];
               dense_cnt_in = drd_pkg::bump_pred(dense_cnt);
            end else begin
               sparse_cnt_in = drd_pkg::bump_pred(sparse_cnt);
            end
         end else begin
            prev_rank_in = new_run ? rank : prev_rank_ff;
            first_in     = 1'b0;
            cur_len_in   = cur_len;
            long_len_in  = long_len;
            long_rank_in = long_rank;
         end
      end
   end

   always_comb begin
      push                   = accept && req.column_end;
      result.predictor_index = 16'(col_cnt);
      result.dense_found     = dense;
      result.dense_rank      = dense ? 32'(long_rank) : 32'd0;
      result.explicit_count  = dense ? expl : cfg.row_total;
      result.storage_offset  = dense ? dense_sum : 48'(sparse_cnt);
      result.dense_index     = dense ? 16'(dense_cnt) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rank_ff  <= '0;
         first_ff      <= 1'b1;
         cur_len_ff    <= '0;
         long_len_ff   <= '0;
         long_rank_ff  <= '0;
         sparse_cnt_ff <= '0;
         dense_cnt_ff  <= '0;
         dense_sum_ff  <= '0;
         col_cnt_ff    <= '0;
      end else begin
         prev_rank_ff  <= prev_rank_in;
         first_ff      <= first_in;
         cur_len_ff    <= cur_len_in;
         long_len_ff   <= long_len_in;
         long_rank_ff  <= long_rank_in;
         sparse_cnt_ff <= sparse_cnt_in;
         dense_cnt_ff  <= dense_cnt_in;
         dense_sum_ff  <= dense_sum_in;
         col_cnt_ff    <= col_cnt_in;
      end
   end

endmodule

// ===== rtl/drd_out_buffer.sv =====
// ----------------------------------------------------------------------------
// drd_out_buffer
// Result register with a skid entry, so one more result can still be taken
// while the receiver stalls.
// ----------------------------------------------------------------------------
module drd_out_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  drd_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drd_pkg::rsp_type rsp_data
);

   logic             out_valid_ff,  out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   drd_pkg::rsp_type out_data_ff,   out_data_in;
   drd_pkg::rsp_type skid_data_ff,  skid_data_in;
   logic             pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed while the skid entry is occupied");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry did not move into the output register");

endmodule

// ===== rtl/dense_run_detector.sv =====
// ----------------------------------------------------------------------------
// dense_run_detector
// Finds the longest equal-rank run of each predictor column and assigns its
// storage offset.
//
// The req channel carries one run per transfer; the run flagged column_end
// closes its column and produces exactly one transfer on the rsp channel.
// Runs without column_end produce no result. A run with new_frame clears the
// column counter and the offset accumulators before it is processed.
// The block accepts one run every cycle while req_stall is low. The closing
// run's result is registered, into the skid entry if the receiver stalls.
// Each run is handled in one pass through the run tracker, which updates its
// state at the transfer edge. The result register is backed by a skid entry:
// when the receiver stalls, a second result can still be captured, and
// req_stall rises only while that skid entry is occupied.
// The configuration registers row_total (address 0) and dense_threshold
// (address 4) are written over the APB-style port; pready is always high.
// Synchronous reset clears all run state, the accumulators, both registers
// and the valid flags of the result buffer.
// ----------------------------------------------------------------------------
module dense_run_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  drd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output drd_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [drd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [drd_pkg::DATA_BITS-1:0] pwdata,
   output logic [drd_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready
);

   drd_pkg::cfg_type cfg;
   drd_pkg::rsp_type result;
   logic             accept;
   logic             push;
   logic             full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   drd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   drd_run_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .push   (push),
      .result (result)
   );

   drd_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/drd_result_monitor.sv =====
// ----------------------------------------------------------------------------
// drd_result_monitor
// Watches the run, result and register ports of the dense run detector.
// Every accepted run updates a local model of the run tracker and of the
// offset accumulators. Each closed column queues the result it must produce.
// Every accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module drd_result_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  drd_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  drd_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [drd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [drd_pkg::DATA_BITS-1:0] pwdata,
   input  logic                          pready,
   output int unsigned                   mismatch_count,
   output int unsigned                   results_owed
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PB = drd_pkg::PRED_BITS;
   localparam int RB = drd_pkg::RANK_CMP_BITS;

   localparam logic [drd_pkg::ADDR_BITS-1:0] ADDR_ROW_TOTAL =
      {drd_pkg::REG_ROW_TOTAL, 2'b00};
   localparam logic [drd_pkg::ADDR_BITS-1:0] ADDR_DENSE_THRESHOLD =
      {drd_pkg::REG_DENSE_THRESHOLD, 2'b00};

   logic [31:0]      cfg_rows;
   logic [31:0]      cfg_floor;
   logic [31:0]      run_prev_rank;
   logic             run_fresh;
   logic [31:0]      run_len;
   logic [31:0]      best_len;
   logic [31:0]      best_rank;
   logic [PB-1:0]    sparse_seen;
   logic [PB-1:0]    dense_seen;
   logic [PB-1:0]    column_seen;
   logic [47:0]      dense_offset_sum;
   drd_pkg::rsp_type column_results[$];

   function automatic logic [PB-1:0] next_ordinal(input logic [PB-1:0] v);
      return (v == drd_pkg::PRED_MAX) ? v : v + PB'(1);
   endfunction

   task automatic forget_column();
      run_prev_rank = '0;
      run_fresh     = 1'b1;
      run_len       = '0;
      best_len      = '0;
      best_rank     = '0;
   endtask

   task automatic track_run(input drd_pkg::req_type r);
      logic [32:0]      merged;
      logic [48:0]      grown;
      logic             dense;
      logic [31:0]      rank;
      drd_pkg::rsp_type res;
      rank = 32'(r.run_rank[RB-1:0]);
      if (r.new_frame) begin
         sparse_seen      = '0;
         dense_seen       = '0;
         column_seen      = '0;
         dense_offset_sum = '0;
      end
      if (run_fresh || rank != run_prev_rank) begin
         run_len       = r.run_extent;
         run_prev_rank = rank;
      end else begin
         merged  = {1'b0, run_len} + {1'b0, r.run_extent};
         run_len = merged[32] ? drd_pkg::LEN_MAX : merged[31:0];
      end
      run_fresh = 1'b0;
      if (run_len > best_len) begin
         best_len  = run_len;
         best_rank = rank;
      end
      if (r.column_end) begin
         dense               = best_len > cfg_floor;
         res                 = '0;
         res.predictor_index = 16'(column_seen);
         res.dense_found     = dense;
         if (dense) begin
            res.dense_rank     = best_rank;
            res.explicit_count = (best_len > cfg_rows) ? 32'd0 : cfg_rows - best_len;
            res.storage_offset = dense_offset_sum;
            grown              = {1'b0, dense_offset_sum} + 49'(res.explicit_count);
            dense_offset_sum   = grown[48] ? drd_pkg::SUM_MAX : grown[47:0];
            res.dense_index    = 16'(dense_seen);
            dense_seen         = next_ordinal(dense_seen);
         end else begin
            res.explicit_count = cfg_rows;
            res.storage_offset = 48'(sparse_seen);
            sparse_seen        = next_ordinal(sparse_seen);
         end
         column_seen = next_ordinal(column_seen);
         column_results.push_back(res);
         forget_column();
      end
   endtask

   task automatic check_result(input drd_pkg::rsp_type got);
      drd_pkg::rsp_type want;
      if (column_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result transfer with no column pending: %h", $realtime, got);
      end else begin
         want = column_results.pop_front();
         if (got.predictor_index !== want.predictor_index ||
             got.dense_found     !== want.dense_found     ||
             got.dense_rank      !== want.dense_rank      ||
             got.explicit_count  !== want.explicit_count  ||
             got.storage_offset  !== want.storage_offset  ||
             got.dense_index     !== want.dense_index) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: expected idx=%0d dense=%b rank=%h expl=%h off=%h didx=%0d",
                        $realtime, want.predictor_index, want.dense_found, want.dense_rank,
                        want.explicit_count, want.storage_offset, want.dense_index);
               $display("%0t:   actual idx=%0d dense=%b rank=%h expl=%h off=%h didx=%0d",
                        $realtime, got.predictor_index, got.dense_found, got.dense_rank,
                        got.explicit_count, got.storage_offset, got.dense_index);
            end
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_rows         = '0;
         cfg_floor        = '0;
         sparse_seen      = '0;
         dense_seen       = '0;
         column_seen      = '0;
         dense_offset_sum = '0;
         forget_column();
         column_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_ROW_TOTAL)
               cfg_rows = pwdata;
            else if (paddr == ADDR_DENSE_THRESHOLD)
               cfg_floor = pwdata;
         end
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (req_valid && !req_stall)
            track_run(req_data);
      end
      results_owed = column_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the dense run detector.
// A short directed pass covers saturating merges, zero extents, long runs
// above the row count and frame restarts. Random columns follow under several
// register settings. A final stretch of single-run columns runs without any
// idling on either side. The monitor predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int STRETCH_COLUMNS = 40;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   drd_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   drd_pkg::rsp_type              rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [drd_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [drd_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [drd_pkg::DATA_BITS-1:0] prdata;
   logic                          pready;
   int unsigned                   mismatch_count;
   int unsigned                   results_owed;
   int                            idle_pct = 37;
   int                            runs_sent = 0;

   dense_run_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   drd_result_monitor result_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   task automatic send_run(input logic [31:0] rank, input logic [31:0] extent,
                           input logic last, input logic frame);
      drd_pkg::req_type r;
      r.run_rank   = rank;
      r.run_extent = extent;
      r.column_end = last;
      r.new_frame  = frame;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      runs_sent++;
   endtask

   task automatic drain_columns();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_limits(input logic [31:0] rows, input logic [31:0] floor_rows);
      drain_columns();
      csr_write(drd_pkg::REG_ROW_TOTAL, rows);
      csr_write(drd_pkg::REG_DENSE_THRESHOLD, floor_rows);
   endtask

   task automatic random_column();
      int          runs;
      logic [31:0] rank;
      logic [31:0] extent;
      logic        noisy;
      runs  = $urandom_range(1, 6);
      noisy = ($urandom_range(9) == 0);
      for (int i = 0; i < runs; i++) begin
         if (noisy) begin
            send_run($urandom(), $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            rank = ($urandom_range(9) < 7) ? 32'($urandom_range(3)) : $urandom();
            case ($urandom_range(19))
               0:       extent = 32'd0;
               1:       extent = 32'hFFFF_FFFF;
               2:       extent = $urandom();
               default: extent = $urandom_range(1, 12);
            endcase
            send_run(rank, extent, i == runs - 1, $urandom_range(29) == 0);
         end
      end
   endtask

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[dense_run_detector] ERROR");
      $finish;
   end

   initial begin
      int target;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_limits(32'd100, 32'd10);
      send_run(32'd0, 32'd200, 1'b1, 1'b1);
      send_run(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_run(32'hFFFF_FFFF, 32'd5, 1'b1, 1'b0);
      send_run(32'd7, 32'd0, 1'b0, 1'b0);
      send_run(32'd7, 32'd0, 1'b1, 1'b0);
      send_run(32'd3, 32'd4, 1'b0, 1'b0);
      send_run(32'd5, 32'd6, 1'b0, 1'b0);
      send_run(32'd5, 32'd6, 1'b1, 1'b0);
      send_run(32'd0, 32'd1, 1'b0, 1'b0);
      send_run(32'd0, 32'd3, 1'b1, 1'b0);
      send_run(32'd9, 32'd11, 1'b0, 1'b1);
      send_run(32'd2, 32'd1, 1'b1, 1'b0);
      send_run(32'hA5A5_A5A5, 32'd1, 1'b1, 1'b0);
      send_run(32'd8, 32'd5, 1'b0, 1'b0);
      send_run(32'd8, 32'd0, 1'b1, 1'b0);
      set_limits(32'hFFFF_FFFF, 32'd0);
      send_run(32'd1, 32'd1, 1'b1, 1'b0);
      send_run(32'h5A5A_5A5A, 32'h1234_5678, 1'b1, 1'b0);
      set_limits(32'd0, 32'hFFFF_FFFF);
      send_run(32'd4, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_run(32'd0, 32'd0, 1'b1, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       set_limits(32'd50, 32'd8);
            1:       set_limits(32'hFFFF_FFFF, 32'd0);
            2:       set_limits(32'd0, 32'hFFFF_FFFF);
            3:       set_limits($urandom_range(60), $urandom_range(20));
            default: set_limits($urandom(), $urandom_range(40));
         endcase
         target = runs_sent + 240;
         while (runs_sent < target) begin
            random_column();
            if (phase == 4 && runs_sent > target - 130 && runs_sent < target - 124)
               drain_columns();
         end
      end

      set_limits(32'd77, 32'hFFFF_FFFF);
      idle_pct = 0;
      for (int i = 0; i < STRETCH_COLUMNS; i++)
         send_run($urandom(), 32'd1, 1'b1, i == 0);
      set_limits(32'hFFFF_FFFF, 32'd0);
      for (int i = 0; i < STRETCH_COLUMNS; i++)
         send_run($urandom(), 32'd1, 1'b1, i == 0);
      idle_pct = 37;

      drain_columns();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("[dense_run_detector] OK");
      else
         $display("[dense_run_detector] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/drd_pkg.sv
rtl/drd_csr.sv
rtl/drd_run_tracker.sv
rtl/drd_out_buffer.sv
rtl/dense_run_detector.sv
dv/drd_result_monitor.sv
dv/testbench.sv
